/* design/mlsd_pkg.sv */
`default_nettype none

package mlsd_pkg;

  // Default limb width, and the fixed width of the remainder and divisor words.
  localparam int LIMB_BITS_DEF = 64;
  localparam int WORD_BITS     = 64;

  // Configuration port geometry: 64-bit registers at byte addresses 8*i.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;

  // Streaming payload widths, padded to whole bytes.
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 136;

  typedef enum logic [1:0] {
    REG_DIVISOR = 2'd0,
    REG_DIV_NEG = 2'd1,
    REG_SIGNED  = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  // Requests from the stream control to the bit-serial divider.
  typedef struct packed {
    logic start;
    logic clear_rem;
    logic ack;
  } div_ctl_t;

  // Status of the bit-serial divider.
  typedef struct packed {
    logic ready;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* design/mlsd_div.sv */
`default_nettype none

module mlsd_div #(
  parameter int LIMB_BITS = mlsd_pkg::LIMB_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire mlsd_pkg::div_ctl_t             ctl,
  input  wire logic [LIMB_BITS-1:0]           limb,
  input  wire logic [mlsd_pkg::WORD_BITS-1:0] divisor,
  output      mlsd_pkg::div_stat_t            stat,
  output      logic [LIMB_BITS-1:0]           quotient,
  output      logic [mlsd_pkg::WORD_BITS-1:0] remainder
);
  import mlsd_pkg::*;

  localparam int CNT_W = (LIMB_BITS > 1) ? $clog2(LIMB_BITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LIMB_BITS - 1);

  div_state_t           state;
  div_state_t           state_next;
  logic [CNT_W-1:0]     cnt;
  logic [LIMB_BITS-1:0] limb_sr;

  logic                 carry;
  logic                 take;
  logic [WORD_BITS-1:0] shifted;
  logic [WORD_BITS-1:0] diff;

  // One restoring step: shift in the next numerator bit, subtract when it fits
  // or when the shifted-out bit says the value already exceeds 64 bits.
  assign carry   = remainder[WORD_BITS-1];
  assign shifted = {remainder[WORD_BITS-2:0], limb_sr[LIMB_BITS-1]};
  assign diff    = shifted - divisor;
  assign take    = carry || (shifted >= divisor);

  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: begin
        if (ctl.start) state_next = DIV_RUN;
      end
      DIV_RUN: begin
        if (cnt == '0) state_next = DIV_DONE;
      end
      DIV_DONE: begin
        if (ctl.ack) state_next = DIV_IDLE;
      end
      default: state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    stat.ready = 1'b0;
    stat.done  = 1'b0;
    unique case (state)
      DIV_IDLE: stat.ready = 1'b1;
      DIV_RUN:  ;
      DIV_DONE: stat.done  = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= DIV_IDLE;
      remainder <= '0;
    end else begin
      state <= state_next;
      if (state == DIV_IDLE && ctl.start && ctl.clear_rem) begin
        remainder <= '0;
      end else if (state == DIV_RUN) begin
        remainder <= take ? diff : shifted;
      end else if (state == DIV_DONE && ctl.ack && divisor == '0) begin
        // A zero divisor leaves nothing to carry into the next limb.
        remainder <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && ctl.start) begin
      limb_sr <= limb;
      cnt     <= CNT_LAST;
    end else if (state == DIV_RUN) begin
      limb_sr  <= {limb_sr[LIMB_BITS-2:0], 1'b0};
      quotient <= {quotient[LIMB_BITS-2:0], take};
      cnt      <= cnt - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

/* design/multi_limb_short_divider_top.sv */
`default_nettype none
// Multi-limb short divider: divides a sign-magnitude numerator, streamed in as
// limbs with the most significant limb first, by a configured single-word divisor.
// Input channel (s_*): one limb per transfer; tuser marks the first limb of a
// number, which clears the running remainder and samples the numerator sign;
// tlast marks the least significant limb. Output channel (m_*): one result
// per input transfer carrying the quotient limb, the signs, the running
// remainder (the final remainder when tlast is set) and a divide-error flag.
// The divisor and mode registers sit behind an APB-style port; the user must
// write them only while no limb is in flight, as the block does not enforce it.
// A result enters the output register once the divider has finished its limb
// and that register is empty or being drained; a new limb is taken only after
// the previous result has left the divider. The radix-2 restoring divider retires
// one quotient bit per cycle; each limb depends on the remainder of the one before.
// Reset clears the running remainder and the held sign, sets the divisor to
// one and the mode bits to zero, and empties the output register.
// When the receiver stalls, the finished result waits in the output register
// and the divider holds its next result; input stays blocked until that held
// result moves into the output register.
module multi_limb_short_divider_top #(
  parameter int LIMB_BITS = mlsd_pkg::LIMB_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input stream.
  input  wire logic                            s_tvalid,
  output      logic                            s_tready,
  // s_tdata: limb [63:0], numerator_negative [64], zero padding [71:65]
  input  wire logic [mlsd_pkg::S_TDATA_W-1:0]  s_tdata,
  // s_tuser: first_limb [0]
  input  wire logic                            s_tuser,
  input  wire logic                            s_tlast,
  // Output stream.
  output      logic                            m_tvalid,
  input  wire logic                            m_tready,
  // m_tdata: quotient_limb [63:0], quotient_negative [64],
  //          remainder_magnitude [128:65], remainder_negative [129], zeros [135:130]
  output      logic [mlsd_pkg::M_TDATA_W-1:0]  m_tdata,
  // m_tuser: divide_error [0]
  output      logic                            m_tuser,
  output      logic                            m_tlast,
  // Configuration port.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mlsd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [mlsd_pkg::APB_DATA_W-1:0] pwdata,
  output      logic [mlsd_pkg::APB_DATA_W-1:0] prdata,
  output      logic                            pready
);
  import mlsd_pkg::*;

  // Configuration registers.
  logic [WORD_BITS-1:0] divisor_magnitude;
  logic                 divisor_negative;
  logic                 signed_mode;

  // Numerator context.
  logic                 held_sign;
  logic                 last_hold;

  reg_index_t           reg_sel;
  logic                 cfg_write;

  div_ctl_t             div_ctl;
  div_stat_t            div_stat;
  logic [LIMB_BITS-1:0] div_quotient;
  logic [WORD_BITS-1:0] div_remainder;

  logic                 accept;
  logic                 load;
  logic                 div_err;
  logic [WORD_BITS-1:0] quot_word;
  logic [WORD_BITS-1:0] rem_word;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = reg_index_t'(paddr[APB_ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor_magnitude <= WORD_BITS'(1);
      divisor_negative  <= 1'b0;
      signed_mode       <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_DIVISOR: divisor_magnitude <= pwdata[WORD_BITS-1:0];
        REG_DIV_NEG: divisor_negative  <= pwdata[0];
        REG_SIGNED:  signed_mode       <= pwdata[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_DIVISOR: prdata = APB_DATA_W'(divisor_magnitude);
      REG_DIV_NEG: prdata = APB_DATA_W'(divisor_negative);
      REG_SIGNED:  prdata = APB_DATA_W'(signed_mode);
      default:     prdata = '0;
    endcase
  end

  // A new limb is taken only while the divider is idle; the result path is
  // released whenever the output register is empty or being drained.
  assign s_tready          = div_stat.ready;
  assign accept            = s_tvalid && s_tready;
  assign div_ctl.start     = accept;
  assign div_ctl.clear_rem = s_tuser;
  assign div_ctl.ack       = !m_tvalid || m_tready;
  assign load              = div_stat.done && div_ctl.ack;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_sign <= 1'b0;
    end else if (accept && s_tuser) begin
      held_sign <= s_tdata[WORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) last_hold <= s_tlast;
  end

  mlsd_div #(
    .LIMB_BITS (LIMB_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (div_ctl),
    .limb      (s_tdata[LIMB_BITS-1:0]),
    .divisor   (divisor_magnitude),
    .stat      (div_stat),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // A zero divisor forces a zero quotient and remainder and raises the flag.
  assign div_err   = (divisor_magnitude == '0);
  assign quot_word = div_err ? '0 : WORD_BITS'(div_quotient);
  assign rem_word  = div_err ? '0 : div_remainder;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {6'b0,
                  signed_mode & held_sign,
                  rem_word,
                  held_sign ^ (signed_mode & divisor_negative),
                  quot_word};
      m_tuser <= div_err;
      m_tlast <= last_hold;
    end
  end

endmodule

`default_nettype wire

/* design/mlsd_checker.sv */
`default_nettype none

module mlsd_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [mlsd_pkg::M_TDATA_W-1:0]  m_tdata,
  input wire logic                            m_tuser,
  input wire logic                            m_tlast
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // A divide error gives zero quotient and zero remainder.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[63:0] == '0 && m_tdata[128:65] == '0)
    else $error("nonzero result with divide error");

  // The divider works on one limb at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while divider busy");

endmodule

bind multi_limb_short_divider_top mlsd_checker u_mlsd_checker (.*);

`default_nettype wire

/* tb/multi_limb_short_divider_top_tb.sv */
`timescale 1ns / 100ps

// One result of a limb division, in the order the output stream carries it.
typedef struct packed {
  logic [63:0] quotient;
  logic        quotient_neg;
  logic [63:0] remainder;
  logic        remainder_neg;
  logic        last;
  logic        div_error;
} limb_result_t;

// Keeps its own copy of the divisor registers and the running remainder,
// predicts the result of every accepted limb and checks the results in order.
class limb_division_tracker;
  logic [63:0]  divisor;
  logic         divisor_neg;
  logic         signed_on;
  logic [63:0]  remainder;
  logic         held_neg;
  logic [63:0]  limb_mask;
  limb_result_t pending_quotients[$];
  int           mismatches;

  function new();
    divisor     = 64'd1;
    divisor_neg = 1'b0;
    signed_on   = 1'b0;
    remainder   = '0;
    held_neg    = 1'b0;
    mismatches  = 0;
    limb_mask   = '1;
    if (mlsd_pkg::LIMB_BITS_DEF < 64) begin
      limb_mask = (64'd1 << mlsd_pkg::LIMB_BITS_DEF) - 64'd1;
    end
  endfunction

  function void set_register(mlsd_pkg::reg_index_t idx, logic [63:0] value);
    case (idx)
      mlsd_pkg::REG_DIVISOR: divisor = value;
      mlsd_pkg::REG_DIV_NEG: divisor_neg = value[0];
      mlsd_pkg::REG_SIGNED:  signed_on = value[0];
      default: ;
    endcase
  endfunction

  // Restoring division of {remainder, limb} by the divisor, one bit per step.
  // The carry out of the shift forces a subtraction, so a remainder left over
  // from a larger divisor still wraps the way the hardware does.
  function void note_limb(logic [63:0] limb, logic first, logic last, logic num_neg);
    limb_result_t res;
    logic [63:0]  bits;
    logic [63:0]  r;
    logic [63:0]  q;
    logic         carry;
    bits = limb & limb_mask;
    q    = '0;
    if (first) begin
      remainder = '0;
      held_neg  = num_neg;
    end
    if (divisor == 64'd0) begin
      remainder = '0;
    end else begin
      r = remainder;
      for (int i = mlsd_pkg::LIMB_BITS_DEF - 1; i >= 0; i--) begin
        carry = r[63];
        r     = {r[62:0], bits[i]};
        q     = {q[62:0], 1'b0};
        if (carry || r >= divisor) begin
          r    = r - divisor;
          q[0] = 1'b1;
        end
      end
      remainder = r;
    end
    res.quotient      = q & limb_mask;
    res.quotient_neg  = held_neg ^ (signed_on & divisor_neg);
    res.remainder     = remainder;
    res.remainder_neg = signed_on & held_neg;
    res.last          = last;
    res.div_error     = (divisor == 64'd0);
    pending_quotients.push_back(res);
  endfunction

  function void flag(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s: expected %h, got %h", what, want, got);
    end
  endfunction

  function void check_quotient(limb_result_t got);
    limb_result_t want;
    if (pending_quotients.size() == 0) begin
      flag("quotient_limb of a result with nothing expected", '0, got.quotient);
      return;
    end
    want = pending_quotients.pop_front();
    if (got.quotient !== want.quotient) flag("quotient_limb", want.quotient, got.quotient);
    if (got.quotient_neg !== want.quotient_neg) begin
      flag("quotient_negative", want.quotient_neg, got.quotient_neg);
    end
    if (got.remainder !== want.remainder) begin
      flag("remainder_magnitude", want.remainder, got.remainder);
    end
    if (got.remainder_neg !== want.remainder_neg) begin
      flag("remainder_negative", want.remainder_neg, got.remainder_neg);
    end
    if (got.last !== want.last) flag("last", want.last, got.last);
    if (got.div_error !== want.div_error) flag("divide_error", want.div_error, got.div_error);
  endfunction

  function int pending();
    return pending_quotients.size();
  endfunction
endclass

module multi_limb_short_divider_top_tb;

  // The drain pause after the last expected result covers one full division
  // plus some margin.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 800;
  localparam int RANDOM_ITEMS = 1150;
  localparam int SEGMENTS     = 7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [mlsd_pkg::S_TDATA_W-1:0]    s_tdata  = '0;
  logic                              s_tuser  = 1'b0;
  logic                              s_tlast  = 1'b0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [mlsd_pkg::M_TDATA_W-1:0]    m_tdata;
  logic                              m_tuser;
  logic                              m_tlast;
  logic                              psel     = 1'b0;
  logic                              penable  = 1'b0;
  logic                              pwrite   = 1'b0;
  logic [mlsd_pkg::APB_ADDR_W-1:0]   paddr    = '0;
  logic [mlsd_pkg::APB_DATA_W-1:0]   pwdata   = '0;
  logic [mlsd_pkg::APB_DATA_W-1:0]   prdata;
  logic                              pready;

  limb_division_tracker tracker;

  // Idle chances in percent per cycle for each side, changed by the stimulus
  // as it moves through the idling phases.
  int tx_idle_pct = 33;
  int rx_idle_pct = 71;

  // The long receiver hold is requested by the stimulus and counted down by
  // the receiver process itself.
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  int cycle_count   = 0;
  int sent          = 0;

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  multi_limb_short_divider_top #(
    .LIMB_BITS(mlsd_pkg::LIMB_BITS_DEF)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // The receiver changes tready at the falling edge. During the long hold it
  // refuses every result, which backs the block up until it stops taking limbs.
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      hold_left = HOLD_CYCLES;
      holds_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Both streams are sampled at the rising edge. An accepted limb transfer
  // feeds the predictor and an accepted result transfer is checked against
  // the oldest prediction.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        tracker.note_limb(s_tdata[63:0], s_tuser, s_tlast, s_tdata[64]);
      end
      if (m_tvalid && m_tready) begin
        tracker.check_quotient({m_tdata[63:0], m_tdata[64], m_tdata[128:65],
                                m_tdata[129], m_tlast, m_tuser});
      end
    end
  end

  // Watchdog: the slowest correct run is far below this.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Register write: setup, then access, then an idle phase so that the next
  // write starts in a later step. The local copy follows once the access
  // cycle has completed.
  task automatic write_register(mlsd_pkg::reg_index_t idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_register(idx, value);
    @(negedge clk);
  endtask

  // Lowers valid and waits until every predicted result has been seen, then
  // lets a full division time pass so that the block is truly idle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(logic [63:0] divisor, logic divisor_neg, logic signed_on);
    wait_idle();
    write_register(mlsd_pkg::REG_DIVISOR, divisor);
    write_register(mlsd_pkg::REG_DIV_NEG, {63'd0, divisor_neg});
    write_register(mlsd_pkg::REG_SIGNED, {63'd0, signed_on});
  endtask

  // Entered and left at a falling edge. Valid stays high on return, so the
  // next call either replaces the data in the same step or starts with a gap
  // that lowers it; the caller never leaves it high across a step on its own.
  task automatic send_limb(logic [63:0] limb, logic first, logic last, logic num_neg);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, num_neg, limb};
    s_tuser  <= first;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Limbs lean toward the corners: zero, all ones, small values, single bits.
  function automatic logic [63:0] pick_limb();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(255));
      3:       return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] pick_divisor(int seg);
    case (seg)
      0:       return 64'($urandom_range(16, 1));
      1:       return '1;
      2:       return '0;
      3:       return {1'b1, 31'($urandom), $urandom};
      4:       return {$urandom, $urandom};
      5:       return 64'd1;
      default: return {32'd0, $urandom};
    endcase
  endfunction

  // Random limb with the idling phase chosen by how far the random part has
  // come: sender idles less than the receiver, then the reverse, then neither.
  task automatic send_random_limb(logic first, logic last);
    if (sent < RANDOM_ITEMS / 3) begin
      tx_idle_pct = 33;
      rx_idle_pct = 71;
    end else if (sent < 2 * RANDOM_ITEMS / 3) begin
      tx_idle_pct = 71;
      rx_idle_pct = 33;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    send_limb(pick_limb(), first, last, 1'($urandom_range(1)));
    sent++;
  endtask

  initial begin
    int seg_goal;
    int len;
    tracker = new();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed part. Right after reset, a limb with no first flag continues
    // from the cleared remainder; divisor one passes the limb straight through.
    send_limb('1, 1'b0, 1'b0, 1'b1);
    send_limb('0, 1'b0, 1'b1, 1'b0);
    send_limb(pick_limb(), 1'b1, 1'b1, 1'b1);

    // Largest divisor, signed, negative divisor. The third limb follows a last
    // limb without a first flag and must simply continue the division; the
    // fourth leaves a zero remainder whose sign still follows the numerator.
    configure('1, 1'b1, 1'b1);
    send_limb('1, 1'b1, 1'b0, 1'b1);
    send_limb('1, 1'b0, 1'b1, 1'b0);
    send_limb('0, 1'b0, 1'b0, 1'b1);
    send_limb('0, 1'b1, 1'b1, 1'b1);

    // Divisor changed inside a number: the remainder left by the large divisor
    // is far above the new one, so the carry path of the shift is exercised.
    configure(64'h8000_0000_0000_0001, 1'b0, 1'b1);
    send_limb(pick_limb(), 1'b1, 1'b0, 1'b1);
    configure(64'd3, 1'b0, 1'b1);
    send_limb('1, 1'b0, 1'b1, 1'b0);

    // Zero divisor: error flag, zero quotient, remainder cleared.
    configure('0, 1'b1, 1'b0);
    send_limb(pick_limb(), 1'b1, 1'b0, 1'b1);
    send_limb(pick_limb(), 1'b0, 1'b1, 1'b0);

    configure(64'h8000_0000_0000_0000, 1'b0, 1'b1);
    send_limb('1, 1'b1, 1'b0, 1'b1);
    send_limb(pick_limb(), 1'b0, 1'b1, 1'b0);

    // Random part: one divisor setting per segment, with both signs and both
    // modes across the segments. Most traffic is well-formed numbers of a few
    // limbs; the rest carries random first and last flags.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      configure(pick_divisor(seg), 1'((seg >> 1) & 1), 1'(seg & 1));
      if (seg == 1) hold_requests++;
      seg_goal = (seg + 1) * RANDOM_ITEMS / SEGMENTS;
      while (sent < seg_goal) begin
        if ($urandom_range(99) < 85) begin
          len = $urandom_range(6, 1);
          for (int k = 0; k < len; k++) begin
            send_random_limb(k == 0, k == len - 1);
          end
        end else begin
          len = $urandom_range(3, 1);
          repeat (len) send_random_limb(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      end
    end

    wait_idle();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
